### hdl/clock_control_register_block_defines.svh
// assertion macros used by the clock control register block port checker
// no dependencies; expects signals named clk and rst_n in the scope of use
`ifndef CLOCK_CONTROL_REGISTER_BLOCK_DEFINES_SVH
`define CLOCK_CONTROL_REGISTER_BLOCK_DEFINES_SVH

// checked on every rising edge outside reset
`define CCRB_ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ccrb assertion failed");

// checked on every rising edge, reset included
`define CCRB_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ccrb assertion failed");

`endif

### hdl/ccrb_pkg.sv
// constants, types and helper functions of the clock control register block
// no dependencies
`timescale 1ns / 1ps

package ccrb_pkg;

    localparam int REG_WORDS = 16384;
    localparam int NUM_PLLS  = 5;

    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 32;
    localparam int WORD_W    = ADDR_W - 2;
    localparam int IDX_W     = $clog2(REG_WORDS);
    localparam int FREQ_W    = 38;
    localparam int FREF_W    = 26;
    localparam int PLL_IDX_W = (NUM_PLLS > 1) ? $clog2(NUM_PLLS) : 1;
    localparam int PLL_NUM_W = 3;
    localparam int LINE_W    = 2;

    localparam logic [ADDR_W-1:0] PLL_BASE   = 16'h1360;
    localparam logic [ADDR_W-1:0] PLL_STRIDE = 16'h0028;
    localparam logic [ADDR_W-1:0] PLL_END    = 16'(32'h1360 + 32'h28 * NUM_PLLS);

    localparam logic [ADDR_W-1:0] ADDR_CORE_RST   = 16'h040c;
    localparam logic [ADDR_W-1:0] ADDR_CORE_START = 16'h0434;
    localparam logic [ADDR_W-1:0] ADDR_PWR        = 16'h0440;
    localparam logic [ADDR_W-1:0] ADDR_BKP_SET    = 16'h049c;
    localparam logic [ADDR_W-1:0] ADDR_BKP_CLR    = 16'h04a0;
    localparam logic [ADDR_W-1:0] ADDR_BKP        = 16'h04a4;
    localparam logic [ADDR_W-1:0] ADDR_RESET_WORD = 16'h04d0;
    localparam logic [ADDR_W-1:0] ADDR_LINE_ADC0  = 16'h07e8;
    localparam logic [ADDR_W-1:0] ADDR_LINE_ADC1  = 16'h07ec;
    localparam logic [ADDR_W-1:0] ADDR_LINE_SD    = 16'h0830;
    localparam logic [ADDR_W-1:0] ADDR_SRC_SEL    = 16'h1000;
    localparam logic [ADDR_W-1:0] ADDR_ID         = 16'hfff8;

    localparam logic [DATA_W-1:0] ID_VALUE         = 32'h80000003;
    localparam logic [DATA_W-1:0] RESET_WORD_VALUE = 32'h80000000;
    localparam logic [DATA_W-1:0] PLL_READY_MASK   = 32'h01000000;
    localparam logic [DATA_W-1:0] BKP_MASK         = 32'h00000101;

    localparam int PLL_EN_BIT  = 8;
    localparam int PLL_BYP_BIT = 10;
    localparam int PLL_OEN_BIT = 9;
    localparam int PWR_SRC_HI  = 9;
    localparam int PWR_DST_HI  = 10;
    localparam int PWR_DST_LO  = 2;

    localparam int PLL_READS = 5;
    localparam int MUL_STEPS = 5;
    localparam int DIVS_W    = 11;
    localparam int PROD_W    = 50;
    localparam int MUL_A_W   = 26;
    localparam int MUL_B_W   = 24;

    localparam logic [LINE_W-1:0] LINE_ADC0 = 2'd0;
    localparam logic [LINE_W-1:0] LINE_ADC1 = 2'd1;
    localparam logic [LINE_W-1:0] LINE_SD   = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0]    rdata;
        logic                 pll_update;
        logic [PLL_NUM_W-1:0] pll_number;
        logic [FREQ_W-1:0]    pll_freq_hz;
        logic                 line_update;
        logic [LINE_W-1:0]    line_select;
        logic                 line_level;
        logic                 core_reset_req;
        logic                 core_start_req;
    } rsp_t;

    // reference frequency for a source select code
    function automatic logic [FREF_W-1:0] fref_hz(input logic [1:0] sel);
        logic [FREF_W-1:0] f;
        case (sel)
            2'd0:    f = 26'd64000000;
            2'd1:    f = 26'd40000000;
            2'd2:    f = 26'd4000000;
            default: f = '0;
        endcase
        return f;
    endfunction

    // word offsets of the pll setting words fetched after a control write
    function automatic logic [WORD_W-1:0] pll_word_off(input logic [2:0] idx);
        logic [WORD_W-1:0] off;
        case (idx)
            3'd0:    off = WORD_W'(1);
            3'd1:    off = WORD_W'(2);
            3'd2:    off = WORD_W'(3);
            3'd3:    off = WORD_W'(6);
            3'd4:    off = WORD_W'(7);
            default: off = '0;
        endcase
        return off;
    endfunction

    function automatic logic word_in_range(input logic [WORD_W-1:0] w);
        return ({1'b0, w} < (WORD_W + 1)'(REG_WORDS));
    endfunction

endpackage

### hdl/ccrb_req_if.sv
// request channel of the clock control register block: one word access per item
// depends on ccrb_pkg
`timescale 1ns / 1ps

interface ccrb_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [ccrb_pkg::ADDR_W-1:0] addr;
    logic [ccrb_pkg::DATA_W-1:0] wdata;

    modport source (output valid, output op, output addr, output wdata, input ready);
    modport sink   (input valid, input op, input addr, input wdata, output ready);
endinterface

### hdl/ccrb_rsp_if.sv
// response channel of the clock control register block: one result per access
// depends on ccrb_pkg
`timescale 1ns / 1ps

interface ccrb_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ccrb_pkg::DATA_W-1:0]    rdata;
    logic                           pll_update;
    logic [ccrb_pkg::PLL_NUM_W-1:0] pll_number;
    logic [ccrb_pkg::FREQ_W-1:0]    pll_freq_hz;
    logic                           line_update;
    logic [ccrb_pkg::LINE_W-1:0]    line_select;
    logic                           line_level;
    logic                           core_reset_req;
    logic                           core_start_req;

    modport source (output valid, output rdata, output pll_update, output pll_number,
                    output pll_freq_hz, output line_update, output line_select,
                    output line_level, output core_reset_req, output core_start_req,
                    input ready);
    modport sink   (input valid, input rdata, input pll_update, input pll_number,
                    input pll_freq_hz, input line_update, input line_select,
                    input line_level, input core_reset_req, input core_start_req,
                    output ready);
endinterface

### hdl/clock_control_register_block.sv
// Clock and reset controller register file with word read/write access; depends on
// ccrb_pkg, ccrb_req_if and ccrb_rsp_if. After reset the block sweeps the 16384-word
// register memory, one word per cycle, and accepts no item until the sweep is done.
// Then one item is worked at a time. A non-id read does a memory read; a core reset
// request also reads the core start word, and a backup set or clear write reads the
// backup word and writes it back. A pll control write with the enable bit set fetches
// five setting words, runs the shared 26x24 multiplier for 5 steps and the shared
// radix-2 divider for 38 steps. When the combined divider is zero the division is
// skipped. The result waits in an output register, and a stalled output register
// holds the block until the result is taken.
`timescale 1ns / 1ps

module clock_control_register_block (
    input  logic       clk,
    input  logic       rst_n,
    ccrb_req_if.sink   req,
    ccrb_rsp_if.source rsp
);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_WRITE = 10'b0000000100,
        S_RADDR = 10'b0000001000,
        S_RCAP  = 10'b0000010000,
        S_WBACK = 10'b0000100000,
        S_MUL   = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    typedef enum logic [3:0] {
        K_READ,
        K_ID,
        K_PLAIN,
        K_PLL_CTL,
        K_CORE_RST,
        K_CORE_START,
        K_BKP_SET,
        K_BKP_CLR,
        K_PWR,
        K_LINE,
        K_SRC_SEL
    } kind_t;

    localparam int DCNT_W = $clog2(ccrb_pkg::FREQ_W);

    state_t state_reg, state_next;
    kind_t  kind_reg, dec_kind;

    logic [ccrb_pkg::IDX_W-1:0]     clr_reg;
    logic                           rsp_valid_reg;
    logic [1:0]                     src_sel_reg [ccrb_pkg::NUM_PLLS];
    logic [2:0]                     idx_reg;
    logic [2:0]                     mstep_reg;
    logic [DCNT_W-1:0]              dcnt_reg;

    logic [ccrb_pkg::ADDR_W-1:0]    addr_reg, dec_addr;
    logic [ccrb_pkg::DATA_W-1:0]    wdata_reg;
    logic [ccrb_pkg::PLL_IDX_W-1:0] k_reg, dec_k;
    logic [ccrb_pkg::LINE_W-1:0]    line_sel_reg, dec_line;
    logic [ccrb_pkg::DATA_W-1:0]    cap_reg;

    logic [11:0]                    mul_reg;
    logic [23:0]                    frac_reg;
    logic [4:0]                     pre_reg;
    logic [2:0]                     d6_reg, d7_reg;
    logic                           byp_reg, oen_reg;

    logic [ccrb_pkg::PROD_W-1:0]    prod_reg;
    logic [ccrb_pkg::FREQ_W-1:0]    acc_reg, quo_reg, freq_reg;
    logic [ccrb_pkg::DIVS_W-1:0]    dvsr_reg, rem_reg;
    ccrb_pkg::rsp_t                 rsp_reg, res;

    logic [ccrb_pkg::DATA_W-1:0]    mem [ccrb_pkg::REG_WORDS];
    logic [ccrb_pkg::DATA_W-1:0]    rdq_reg, rd_val;
    logic                           rd_ok_reg;

    logic                           accept;
    logic                           wr_en;
    logic [ccrb_pkg::WORD_W-1:0]    wr_word, rd_word, item_word;
    logic [ccrb_pkg::DATA_W-1:0]    wr_data, write_value, bkp_value;
    logic [ccrb_pkg::FREF_W-1:0]    fref;
    logic [ccrb_pkg::MUL_A_W-1:0]   mul_a;
    logic [ccrb_pkg::MUL_B_W-1:0]   mul_b;
    logic [ccrb_pkg::DIVS_W:0]      rem_sh, rem_diff;
    logic                           div_ge;
    logic                           out_free;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign item_word = addr_reg[ccrb_pkg::ADDR_W-1:2];
    assign rd_val    = rd_ok_reg ? rdq_reg : '0;
    assign fref      = ccrb_pkg::fref_hz(src_sel_reg[k_reg]);

    // address decode of the incoming item
    always_comb
    begin
        dec_kind = K_PLAIN;
        dec_k    = '0;
        dec_line = ccrb_pkg::LINE_ADC0;
        dec_addr = {req.addr[ccrb_pkg::ADDR_W-1:2], 2'b00};
        if (!req.op)
        begin
            dec_kind = (dec_addr == ccrb_pkg::ADDR_ID) ? K_ID : K_READ;
        end
        else if (dec_addr >= ccrb_pkg::PLL_BASE && dec_addr < ccrb_pkg::PLL_END)
        begin
            for (int k = 0; k < ccrb_pkg::NUM_PLLS; k++)
            begin
                if (dec_addr == ccrb_pkg::PLL_BASE + 16'(k) * ccrb_pkg::PLL_STRIDE)
                begin
                    dec_kind = K_PLL_CTL;
                    dec_k    = ccrb_pkg::PLL_IDX_W'(k);
                end
            end
        end
        else
        begin
            unique case (dec_addr)
                ccrb_pkg::ADDR_CORE_RST:   dec_kind = K_CORE_RST;
                ccrb_pkg::ADDR_CORE_START: dec_kind = K_CORE_START;
                ccrb_pkg::ADDR_BKP_SET:    dec_kind = K_BKP_SET;
                ccrb_pkg::ADDR_BKP_CLR:    dec_kind = K_BKP_CLR;
                ccrb_pkg::ADDR_PWR:        dec_kind = K_PWR;
                ccrb_pkg::ADDR_SRC_SEL:    dec_kind = K_SRC_SEL;
                ccrb_pkg::ADDR_LINE_ADC0:
                begin
                    dec_kind = K_LINE;
                    dec_line = ccrb_pkg::LINE_ADC0;
                end
                ccrb_pkg::ADDR_LINE_ADC1:
                begin
                    dec_kind = K_LINE;
                    dec_line = ccrb_pkg::LINE_ADC1;
                end
                ccrb_pkg::ADDR_LINE_SD:
                begin
                    dec_kind = K_LINE;
                    dec_line = ccrb_pkg::LINE_SD;
                end
                default:                   dec_kind = K_PLAIN;
            endcase
        end
    end

    // word stored by the primary write
    always_comb
    begin
        write_value = wdata_reg;
        case (kind_reg)
            K_PLL_CTL:
            begin
                if (wdata_reg[ccrb_pkg::PLL_EN_BIT])
                    write_value = wdata_reg | ccrb_pkg::PLL_READY_MASK;
                else
                    write_value = wdata_reg & ~ccrb_pkg::PLL_READY_MASK;
            end
            K_CORE_RST:
            begin
                write_value[0] = 1'b0;
            end
            K_PWR:
            begin
                write_value[ccrb_pkg::PWR_DST_HI] = wdata_reg[ccrb_pkg::PWR_SRC_HI];
                write_value[ccrb_pkg::PWR_DST_LO] = wdata_reg[0];
            end
            default: write_value = wdata_reg;
        endcase
    end

    assign bkp_value = (kind_reg == K_BKP_SET) ? (cap_reg | (wdata_reg & ccrb_pkg::BKP_MASK))
                                               : (cap_reg & ~(wdata_reg & ccrb_pkg::BKP_MASK));

    // memory write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_word = item_word;
        wr_data = write_value;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_word = ccrb_pkg::WORD_W'(clr_reg);
                wr_data = (ccrb_pkg::WORD_W'(clr_reg) ==
                           ccrb_pkg::ADDR_RESET_WORD[ccrb_pkg::ADDR_W-1:2])
                          ? ccrb_pkg::RESET_WORD_VALUE : '0;
            end
            S_WRITE:
            begin
                wr_en = 1'b1;
            end
            S_WBACK:
            begin
                wr_en   = 1'b1;
                wr_word = ccrb_pkg::ADDR_BKP[ccrb_pkg::ADDR_W-1:2];
                wr_data = bkp_value;
            end
            default: wr_en = 1'b0;
        endcase
    end

    // memory read address
    always_comb
    begin
        case (kind_reg)
            K_CORE_RST:            rd_word = ccrb_pkg::ADDR_CORE_START[ccrb_pkg::ADDR_W-1:2];
            K_BKP_SET, K_BKP_CLR:  rd_word = ccrb_pkg::ADDR_BKP[ccrb_pkg::ADDR_W-1:2];
            K_PLL_CTL:             rd_word = item_word + ccrb_pkg::pll_word_off(idx_reg);
            default:               rd_word = item_word;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && ccrb_pkg::word_in_range(wr_word))
            mem[wr_word[ccrb_pkg::IDX_W-1:0]] <= wr_data;
        rdq_reg   <= mem[rd_word[ccrb_pkg::IDX_W-1:0]];
        rd_ok_reg <= ccrb_pkg::word_in_range(rd_word);
    end

    // shared multiplier operands
    always_comb
    begin
        case (mstep_reg)
            3'd0:
            begin
                mul_a = fref;
                mul_b = ccrb_pkg::MUL_B_W'(mul_reg);
            end
            3'd1:
            begin
                mul_a = fref;
                mul_b = frac_reg;
            end
            3'd2:
            begin
                mul_a = ccrb_pkg::MUL_A_W'(pre_reg);
                mul_b = ccrb_pkg::MUL_B_W'(d6_reg);
            end
            3'd3:
            begin
                mul_a = prod_reg[ccrb_pkg::MUL_A_W-1:0];
                mul_b = ccrb_pkg::MUL_B_W'(d7_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // one restoring step of the shared divider
    assign rem_sh   = {rem_reg, quo_reg[ccrb_pkg::FREQ_W-1]};
    assign div_ge   = rem_sh >= {1'b0, dvsr_reg};
    assign rem_diff = rem_sh - {1'b0, dvsr_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == ccrb_pkg::IDX_W'(ccrb_pkg::REG_WORDS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (dec_kind == K_READ)
                        state_next = S_RADDR;
                    else if (dec_kind == K_ID)
                        state_next = S_DONE;
                    else
                        state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                case (kind_reg)
                    K_PLL_CTL:
                        state_next = wdata_reg[ccrb_pkg::PLL_EN_BIT] ? S_RADDR : S_DONE;
                    K_CORE_RST:
                        state_next = wdata_reg[0] ? S_RADDR : S_DONE;
                    K_BKP_SET, K_BKP_CLR:
                        state_next = S_RADDR;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_RADDR: state_next = S_RCAP;
            S_RCAP:
            begin
                case (kind_reg)
                    K_PLL_CTL:
                        state_next = (idx_reg == 3'(ccrb_pkg::PLL_READS - 1)) ? S_MUL : S_RADDR;
                    K_BKP_SET, K_BKP_CLR:
                        state_next = S_WBACK;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_WBACK: state_next = S_DONE;
            S_MUL:
            begin
                if (mstep_reg == 3'(ccrb_pkg::MUL_STEPS - 1))
                    state_next = (prod_reg[ccrb_pkg::DIVS_W-1:0] == '0) ? S_FIN : S_DIV;
            end
            S_DIV:
            begin
                if (dcnt_reg == DCNT_W'(ccrb_pkg::FREQ_W - 1))
                    state_next = S_FIN;
            end
            S_FIN:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            idx_reg       <= '0;
            mstep_reg     <= '0;
            dcnt_reg      <= '0;
            for (int k = 0; k < ccrb_pkg::NUM_PLLS; k++)
                src_sel_reg[k] <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR: clr_reg <= clr_reg + 1'b1;
                S_WRITE:
                begin
                    idx_reg   <= '0;
                    mstep_reg <= '0;
                    dcnt_reg  <= '0;
                    if (kind_reg == K_SRC_SEL)
                    begin
                        for (int k = 0; k < ccrb_pkg::NUM_PLLS; k++)
                            src_sel_reg[k] <= wdata_reg[4*k +: 2];
                    end
                end
                S_RCAP:  idx_reg   <= idx_reg + 1'b1;
                S_MUL:   mstep_reg <= mstep_reg + 1'b1;
                S_DIV:   dcnt_reg  <= dcnt_reg + 1'b1;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res                = '0;
        res.rdata          = (kind_reg == K_READ) ? cap_reg :
                             (kind_reg == K_ID)   ? ccrb_pkg::ID_VALUE : '0;
        res.pll_update     = (kind_reg == K_PLL_CTL);
        res.pll_number     = (kind_reg == K_PLL_CTL) ? ccrb_pkg::PLL_NUM_W'(k_reg) : '0;
        res.pll_freq_hz    = freq_reg;
        res.line_update    = (kind_reg == K_LINE);
        res.line_select    = (kind_reg == K_LINE) ? line_sel_reg : '0;
        res.line_level     = (kind_reg == K_LINE) && wdata_reg[0];
        res.core_reset_req = (kind_reg == K_CORE_RST) && wdata_reg[0];
        res.core_start_req = ((kind_reg == K_CORE_RST) && wdata_reg[0] && cap_reg[0]) ||
                             ((kind_reg == K_CORE_START) && wdata_reg[0]);
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_reg     <= dec_kind;
                    addr_reg     <= dec_addr;
                    wdata_reg    <= req.wdata;
                    k_reg        <= dec_k;
                    line_sel_reg <= dec_line;
                    freq_reg     <= '0;
                    cap_reg      <= '0;
                end
            end
            S_RCAP:
            begin
                cap_reg <= rd_val;
                if (kind_reg == K_PLL_CTL)
                begin
                    case (idx_reg)
                        3'd0:
                        begin
                            mul_reg <= rd_val[27:16];
                            pre_reg <= rd_val[4:0];
                        end
                        3'd1: frac_reg <= rd_val[23:0];
                        3'd2:
                        begin
                            byp_reg <= rd_val[ccrb_pkg::PLL_BYP_BIT];
                            oen_reg <= rd_val[ccrb_pkg::PLL_OEN_BIT];
                        end
                        3'd3: d6_reg <= rd_val[2:0];
                        3'd4: d7_reg <= rd_val[2:0];
                        default: ;
                    endcase
                end
            end
            S_MUL:
            begin
                prod_reg <= ccrb_pkg::PROD_W'(mul_a) * ccrb_pkg::PROD_W'(mul_b);
                case (mstep_reg)
                    3'd1: acc_reg <= prod_reg[ccrb_pkg::FREQ_W-1:0];
                    // fractional part: fref*frac over 2^24
                    3'd2: acc_reg <= acc_reg + ccrb_pkg::FREQ_W'(prod_reg[ccrb_pkg::PROD_W-1:24]);
                    // pre * d6 * d7 is one divisor for the three truncating divisions
                    3'd4:
                    begin
                        dvsr_reg <= prod_reg[ccrb_pkg::DIVS_W-1:0];
                        rem_reg  <= '0;
                        quo_reg  <= acc_reg;
                    end
                    default: ;
                endcase
            end
            S_DIV:
            begin
                rem_reg <= div_ge ? rem_diff[ccrb_pkg::DIVS_W-1:0] : rem_sh[ccrb_pkg::DIVS_W-1:0];
                quo_reg <= {quo_reg[ccrb_pkg::FREQ_W-2:0], div_ge};
            end
            S_FIN:
            begin
                if (!oen_reg)
                    freq_reg <= '0;
                else if (byp_reg)
                    freq_reg <= ccrb_pkg::FREQ_W'(fref);
                else if (dvsr_reg == '0)
                    freq_reg <= '0;
                else
                    freq_reg <= quo_reg;
            end
            S_DONE:
            begin
                if (out_free)
                    rsp_reg <= res;
            end
            default: ;
        endcase
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.rdata          = rsp_reg.rdata;
    assign rsp.pll_update     = rsp_reg.pll_update;
    assign rsp.pll_number     = rsp_reg.pll_number;
    assign rsp.pll_freq_hz    = rsp_reg.pll_freq_hz;
    assign rsp.line_update    = rsp_reg.line_update;
    assign rsp.line_select    = rsp_reg.line_select;
    assign rsp.line_level     = rsp_reg.line_level;
    assign rsp.core_reset_req = rsp_reg.core_reset_req;
    assign rsp.core_start_req = rsp_reg.core_start_req;

endmodule

### hdl/ccrb_checker.sv
// port-level checks of the clock control register block, bound to the top level
// depends on ccrb_pkg and clock_control_register_block_defines.svh
`timescale 1ns / 1ps
`include "clock_control_register_block_defines.svh"

module ccrb_prop_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [ccrb_pkg::DATA_W-1:0]    rsp_rdata,
    input logic                           rsp_pll_update,
    input logic [ccrb_pkg::PLL_NUM_W-1:0] rsp_pll_number,
    input logic [ccrb_pkg::FREQ_W-1:0]    rsp_pll_freq_hz,
    input logic                           rsp_line_update
);

    // held result stays offered
    `CCRB_ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)

    `CCRB_ASSERT_ALWAYS(a_no_rsp_in_reset, !rst_n |-> !rsp_valid)

    // one item at a time: no second item right after one is taken
    `CCRB_ASSERT_CLK(a_one_item, req_valid && req_ready |=> !req_ready)

    // a pll item reports no line update and no read data
    `CCRB_ASSERT_CLK(a_pll_alone,
        rsp_valid && rsp_pll_update |-> !rsp_line_update && rsp_rdata == '0)

    `CCRB_ASSERT_CLK(a_no_pll_zero,
        rsp_valid && !rsp_pll_update |-> rsp_pll_freq_hz == '0 && rsp_pll_number == '0)

endmodule

bind clock_control_register_block ccrb_prop_checker u_ccrb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_rdata       (rsp.rdata),
    .rsp_pll_update  (rsp.pll_update),
    .rsp_pll_number  (rsp.pll_number),
    .rsp_pll_freq_hz (rsp.pll_freq_hz),
    .rsp_line_update (rsp.line_update)
);

### dv/ccrb_checker.sv
// scoreboard for the clock control register block: mirrors the register file,
// predicts every response and compares it; depends on ccrb_pkg, ccrb_req_if, ccrb_rsp_if
`timescale 1ns / 1ps

module ccrb_checker
    import ccrb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ccrb_req_if  req,
    ccrb_rsp_if  rsp,
    output int   errors,
    output int   pending,
    output int   pll_writes,
    output int   responses
);

    logic [DATA_W-1:0] reg_image [REG_WORDS];
    logic [1:0]        source_sel [NUM_PLLS];
    rsp_t              expected_rsp [$];

    function automatic logic [63:0] ref_clock(input logic [1:0] sel);
        case (sel)
            2'd0:    return 64'd64000000;
            2'd1:    return 64'd40000000;
            2'd2:    return 64'd4000000;
            default: return 64'd0;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rd_word(input int w);
        return (w < REG_WORDS) ? reg_image[w] : '0;
    endfunction

    // recompute one pll after its control word was stored
    function automatic logic [63:0] pll_output(input int k, input int bw);
        logic [DATA_W-1:0] ctl, w1, w2, w3;
        logic [63:0]       fref, vco, f;
        logic [2:0]        d6, d7;
        logic [4:0]        pre;
        ctl = rd_word(bw);
        if (!ctl[PLL_EN_BIT])
        begin
            if (bw < REG_WORDS) reg_image[bw] = ctl & ~PLL_READY_MASK;
            return 64'd0;
        end
        if (bw < REG_WORDS) reg_image[bw] = ctl | PLL_READY_MASK;
        fref = ref_clock(source_sel[k]);
        w1   = rd_word(bw + 1);
        w2   = rd_word(bw + 2);
        w3   = rd_word(bw + 3);
        d6   = 3'(rd_word(bw + 6));
        d7   = 3'(rd_word(bw + 7));
        pre  = w1[4:0];
        vco  = fref * 64'(w1[27:16]) + ((fref * 64'(w2[23:0])) >> 24);
        vco  = (pre != 0) ? vco / pre : 64'd0;
        vco  = (d6 != 0) ? vco / d6 : 64'd0;
        vco  = (d7 != 0) ? vco / d7 : 64'd0;
        f    = w3[PLL_BYP_BIT] ? fref : vco;
        return w3[PLL_OEN_BIT] ? f : 64'd0;
    endfunction

    function automatic rsp_t predict_access(input logic op, input logic [ADDR_W-1:0] a_in,
                                            input logic [DATA_W-1:0] wd);
        rsp_t              r;
        logic [ADDR_W-1:0] a;
        int                w, k, bw;
        logic [DATA_W-1:0] v;
        r = '0;
        a = {a_in[ADDR_W-1:2], 2'b00};
        w = int'(a >> 2);
        if (!op)
        begin
            r.rdata = (a == ADDR_ID) ? ID_VALUE : rd_word(w);
            return r;
        end
        if (w < REG_WORDS) reg_image[w] = wd;
        if (a >= PLL_BASE && a < PLL_END)
        begin
            k  = int'((a - PLL_BASE) / PLL_STRIDE);
            bw = (int'(PLL_BASE) + k * int'(PLL_STRIDE)) >> 2;
            if (w == bw)
            begin
                r.pll_update  = 1'b1;
                r.pll_number  = PLL_NUM_W'(k);
                r.pll_freq_hz = FREQ_W'(pll_output(k, bw));
            end
            return r;
        end
        case (a)
            ADDR_CORE_RST:
                if (wd[0])
                begin
                    r.core_reset_req = 1'b1;
                    r.core_start_req = 1'(rd_word(int'(ADDR_CORE_START >> 2)));
                    reg_image[w][0] = 1'b0;
                end
            ADDR_CORE_START:
                r.core_start_req = wd[0];
            ADDR_BKP_SET:
                reg_image[ADDR_BKP >> 2] = reg_image[ADDR_BKP >> 2] | (wd & BKP_MASK);
            ADDR_BKP_CLR:
                reg_image[ADDR_BKP >> 2] = reg_image[ADDR_BKP >> 2] & ~(wd & BKP_MASK);
            ADDR_PWR:
            begin
                v = reg_image[w];
                v[PWR_DST_HI] = wd[PWR_SRC_HI];
                v[PWR_DST_LO] = wd[0];
                reg_image[w] = v;
            end
            ADDR_LINE_ADC0, ADDR_LINE_ADC1, ADDR_LINE_SD:
            begin
                r.line_update = 1'b1;
                r.line_select = (a == ADDR_LINE_ADC0) ? LINE_ADC0 :
                                (a == ADDR_LINE_ADC1) ? LINE_ADC1 : LINE_SD;
                r.line_level  = wd[0];
            end
            ADDR_SRC_SEL:
                for (int i = 0; i < NUM_PLLS; i++)
                    source_sel[i] = wd[4*i +: 2];
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
        end
    endtask

    initial
    begin
        errors     = 0;
        pll_writes = 0;
        responses  = 0;
        for (int i = 0; i < REG_WORDS; i++) reg_image[i] = '0;
        for (int i = 0; i < NUM_PLLS; i++) source_sel[i] = 2'd0;
        reg_image[ADDR_RESET_WORD >> 2] = RESET_WORD_VALUE;
    end

    assign pending = expected_rsp.size();

    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && req.valid && req.ready)
        begin
            e = predict_access(req.op, req.addr, req.wdata);
            if (e.pll_update) pll_writes++;
            expected_rsp.push_back(e);
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            responses++;
            if (expected_rsp.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item, expected none actual rdata 0x%0h",
                         $time, rsp.rdata);
            end
            else
            begin
                e = expected_rsp.pop_front();
                check_field("rdata", e.rdata, rsp.rdata);
                check_field("pll_update", e.pll_update, rsp.pll_update);
                check_field("pll_number", e.pll_number, rsp.pll_number);
                check_field("pll_freq_hz", e.pll_freq_hz, rsp.pll_freq_hz);
                check_field("line_update", e.line_update, rsp.line_update);
                check_field("line_select", e.line_select, rsp.line_select);
                check_field("line_level", e.line_level, rsp.line_level);
                check_field("core_reset_req", e.core_reset_req, rsp.core_reset_req);
                check_field("core_start_req", e.core_start_req, rsp.core_start_req);
            end
        end
    end

endmodule

### dv/clock_control_register_block_tb.sv
// top of the clock control register block testbench: clock, reset, access stimulus
// and verdict; depends on ccrb_pkg, the two channel interfaces and ccrb_checker
`timescale 1ns / 1ps

module clock_control_register_block_tb;
    import ccrb_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 850;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   errors, pending, pll_writes, responses;
    int   cycles;
    int   sent;
    int   rsp_stall;

    ccrb_req_if req ();
    ccrb_rsp_if rsp ();

    clock_control_register_block DUT (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    ccrb_checker scoreboard (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .errors(errors), .pending(pending), .pll_writes(pll_writes), .responses(responses)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_stall <= 0;
        end
        else if (rsp_stall > 0)
        begin
            rsp.ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            rsp.ready <= 1'b0;
            rsp_stall <= $urandom_range(0, 10);
        end
        else
            rsp.ready <= 1'b1;
    end

    task automatic access(input logic op, input logic [ADDR_W-1:0] a,
                          input logic [DATA_W-1:0] wd);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op    <= op;
        req.addr  <= a;
        req.wdata <= wd;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        sent++;
    endtask

    function automatic logic [ADDR_W-1:0] pll_addr(input int k, input int off);
        return ADDR_W'(int'(PLL_BASE) + int'(PLL_STRIDE) * k + 4 * off);
    endfunction

    // program all setting words of one pll, then its control word
    task automatic setup_pll(input int k, input logic [DATA_W-1:0] w1,
                             input logic [DATA_W-1:0] w2, input logic [DATA_W-1:0] w3,
                             input logic [DATA_W-1:0] d6, input logic [DATA_W-1:0] d7,
                             input logic [DATA_W-1:0] ctl);
        access(1'b1, pll_addr(k, 1), w1);
        access(1'b1, pll_addr(k, 2), w2);
        access(1'b1, pll_addr(k, 3), w3);
        access(1'b1, pll_addr(k, 6), d6);
        access(1'b1, pll_addr(k, 7), d7);
        access(1'b1, pll_addr(k, 0), ctl);
    endtask

    function automatic logic [ADDR_W-1:0] special_addr();
        case ($urandom_range(0, 11))
            0:  return ADDR_CORE_RST;
            1:  return ADDR_CORE_START;
            2:  return ADDR_PWR;
            3:  return ADDR_BKP_SET;
            4:  return ADDR_BKP_CLR;
            5:  return ADDR_BKP;
            6:  return ADDR_RESET_WORD;
            7:  return ADDR_LINE_ADC0;
            8:  return ADDR_LINE_ADC1;
            9:  return ADDR_LINE_SD;
            10: return ADDR_SRC_SEL;
            default: return ADDR_ID;
        endcase
    endfunction

    initial
    begin
        logic [DATA_W-1:0] wd;
        logic [ADDR_W-1:0] a;
        int                k;
        req.valid = 1'b0;
        req.op    = 1'b0;
        req.addr  = '0;
        req.wdata = '0;
        quiet     = 1'b0;
        sent      = 0;
        @(posedge rst_n);
        @(posedge clk);

        // directed part
        access(1'b0, ADDR_RESET_WORD, '0);
        access(1'b1, ADDR_ID, 32'hffffffff);
        access(1'b0, ADDR_ID | 16'h3, '0);
        access(1'b1, ADDR_SRC_SEL, 32'h00032100);
        setup_pll(0, 32'h0fff001f, 32'h00ffffff, 32'h00000200, 32'h7, 32'h7, 32'h00000101);
        setup_pll(1, 32'h00320001, 32'h0, 32'h00000600, 32'h1, 32'h1, 32'hffffffff);
        access(1'b1, pll_addr(2, 6), 32'h0);
        access(1'b1, pll_addr(2, 0), 32'h00000100);
        access(1'b1, pll_addr(4, 0), 32'h01000000);
        access(1'b1, ADDR_CORE_START, 32'h1);
        access(1'b1, ADDR_CORE_RST, 32'hffffffff);
        access(1'b1, ADDR_CORE_START, 32'h0);
        access(1'b1, ADDR_CORE_RST, 32'h1);
        access(1'b1, ADDR_BKP_SET, 32'hffffffff);
        access(1'b1, ADDR_BKP_CLR, 32'h00000100);
        access(1'b0, ADDR_BKP, '0);
        access(1'b1, ADDR_PWR, 32'h00000201);
        access(1'b1, ADDR_LINE_ADC0, 32'h1);
        access(1'b1, ADDR_LINE_ADC1, 32'h0);
        access(1'b1, ADDR_LINE_SD, 32'hffffffff);
        access(1'b0, 16'hfffc, '0);

        // random part, the tail with no idling
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - 120) quiet = 1'b1;
            wd = $urandom;
            k  = $urandom_range(0, NUM_PLLS - 1);
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    wd[27:16] = $urandom_range(0, 2) == 0 ? wd[27:16] : 12'($urandom_range(1, 200));
                    wd[4:0]   = $urandom_range(0, 9) == 0 ? 5'd0 : 5'($urandom_range(1, 31));
                    a = pll_addr(k, 1);
                end
                2:
                begin
                    if ($urandom_range(0, 3) != 0) wd[PLL_OEN_BIT] = 1'b1;
                    a = pll_addr(k, $urandom_range(0, 1) ? 3 : $urandom_range(2, 9));
                end
                3:  a = pll_addr(k, $urandom_range(6, 7));
                4:
                begin
                    if ($urandom_range(0, 3) != 0) wd[PLL_EN_BIT] = 1'b1;
                    a = pll_addr(k, 0);
                end
                5, 6: a = special_addr();
                7:  a = $urandom_range(0, 1) ? pll_addr(k, $urandom_range(0, 9))
                                             : special_addr();
                default: a = 16'($urandom);
            endcase
            if ($urandom_range(0, 3) == 0) a[1:0] = 2'($urandom);
            access(($urandom_range(0, 9) < 6) ? 1'b1 : 1'b0, a, wd);
        end
        req.valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d accesses, %0d responses, %0d pll control writes",
                 sent, responses, pll_writes);
        $display("directed corner accesses plus random reads and writes over all windows");
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
